FILE: rtl/core/fbf_pkg.sv
// shared constants, field widths and controller/datapath command types
// for the block fir filter; no dependencies
package fbf_pkg;

  localparam int MaxTaps   = 32;
  localparam int IdxW      = $clog2(MaxTaps);
  localparam int TapsW     = 6;
  localparam int SampleW   = 24;
  localparam int CoefW     = 16;
  localparam int ProdW     = SampleW + CoefW;
  localparam int AccW      = ProdW + IdxW + 1;
  localparam int FracBits  = 15;
  localparam int YW        = AccW - FracBits;
  localparam int InDataW   = 48;
  localparam int InUserW   = 2;
  localparam int OutDataW  = 24;
  localparam int OutUserW  = 1;

  localparam logic [TapsW-1:0] TapsReset = TapsW'(MaxTaps);

  // action codes carried in tuser bit 0
  localparam logic ActLoad   = 1'b0;
  localparam logic ActFilter = 1'b1;

  typedef struct packed {
    logic load;   // write one coefficient
    logic start;  // store sample, clear accumulator, rewind tap counter
    logic mac;    // one multiply for the current tap
    logic emit;   // round, saturate and register the result
  } fbf_cmd_t;

  typedef struct packed {
    logic taps_zero;
    logic last_tap;
    logic out_free;
  } fbf_stat_t;

endpackage

FILE: rtl/core/fbf_ctrl.sv
// sequencing state machine for the block fir filter
// depends on fbf_pkg
module fbf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_action_i,
  input  fbf_pkg::fbf_stat_t stat_i,
  output logic              in_ready_o,
  output fbf_pkg::fbf_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StMac,
    StDrain,
    StFinish
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;
  logic   accept;

  assign accept     = in_valid_i & ready_q;
  assign in_ready_o = ready_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_action_i == fbf_pkg::ActLoad) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = stat_i.taps_zero ? StDrain : StMac;
          end
        end
      end
      StMac: begin
        cmd_o.mac = 1'b1;
        if (stat_i.last_tap) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        // last product lands in the accumulator
        state_d = StFinish;
      end
      StFinish: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == StIdle);
    end
  end

endmodule

FILE: rtl/core/fbf_datapath.sv
// coefficient store, sample history, multiply-accumulate and output register
// depends on fbf_pkg
module fbf_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fbf_pkg::fbf_cmd_t                   cmd_i,
  output fbf_pkg::fbf_stat_t                  stat_o,
  input  logic                                cfg_we_i,
  input  logic [fbf_pkg::TapsW-1:0]           cfg_data_i,
  input  logic signed [fbf_pkg::SampleW-1:0]  sample_i,
  input  logic                                first_i,
  input  logic [fbf_pkg::IdxW-1:0]            coef_index_i,
  input  logic signed [fbf_pkg::CoefW-1:0]    coef_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [fbf_pkg::SampleW-1:0]  out_data_o,
  output logic                                out_sat_o
);

  localparam int IdxW = fbf_pkg::IdxW;
  localparam int AccW = fbf_pkg::AccW;
  localparam int YW   = fbf_pkg::YW;
  localparam logic signed [YW-1:0] YMax = YW'((1 << (fbf_pkg::SampleW - 1)) - 1);
  localparam logic signed [YW-1:0] YMin = -YMax - YW'(1);
  localparam logic signed [AccW-1:0] RoundHalf = AccW'(1 << (fbf_pkg::FracBits - 1));

  logic [fbf_pkg::TapsW-1:0]          taps_q, taps_eff;
  logic signed [fbf_pkg::CoefW-1:0]   coef_q [fbf_pkg::MaxTaps];
  logic signed [fbf_pkg::SampleW-1:0] hist_q [fbf_pkg::MaxTaps];
  logic [fbf_pkg::MaxTaps-1:0]        hvalid_q, hvalid_d;
  logic [IdxW-1:0]                    ptr_q, base_q, cnt_q, wr_slot, rd_slot;
  logic signed [fbf_pkg::ProdW-1:0]   prod_q;
  logic                               prod_vld_q;
  logic signed [AccW-1:0]             acc_q, rnd;
  logic signed [YW-1:0]               y;
  logic signed [fbf_pkg::SampleW-1:0] hist_rd;
  logic                               out_valid_q, out_sat_q;
  logic signed [fbf_pkg::SampleW-1:0] out_data_q;

  // counts above the store depth clip to the full length
  assign taps_eff = (taps_q > fbf_pkg::TapsW'(fbf_pkg::MaxTaps))
                    ? fbf_pkg::TapsW'(fbf_pkg::MaxTaps) : taps_q;

  assign stat_o.taps_zero = (taps_eff == '0);
  assign stat_o.last_tap  = ({1'b0, cnt_q} == taps_eff - fbf_pkg::TapsW'(1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign wr_slot = first_i ? '0 : ptr_q;
  // circular walk backwards, wraps with the power-of-two depth
  assign rd_slot = base_q - cnt_q;
  assign hist_rd = hvalid_q[rd_slot] ? hist_q[rd_slot] : '0;

  // block start forgets all older samples
  always_comb begin
    hvalid_d          = first_i ? '0 : hvalid_q;
    hvalid_d[wr_slot] = 1'b1;
  end

  assign rnd = acc_q + RoundHalf;
  assign y   = rnd[AccW-1:fbf_pkg::FracBits];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= fbf_pkg::TapsReset;
      for (int i = 0; i < fbf_pkg::MaxTaps; i++) begin
        coef_q[i] <= '0;
      end
      hvalid_q    <= '0;
      ptr_q       <= '0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        taps_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        coef_q[coef_index_i] <= coef_value_i;
      end
      if (cmd_i.start) begin
        hvalid_q <= hvalid_d;
        ptr_q    <= wr_slot + IdxW'(1);
      end
      prod_vld_q <= cmd_i.mac;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      hist_q[wr_slot] <= sample_i;
      base_q          <= wr_slot;
      cnt_q           <= '0;
      acc_q           <= '0;
    end else begin
      if (prod_vld_q) begin
        acc_q <= acc_q + AccW'(prod_q);
      end
      if (cmd_i.mac) begin
        cnt_q <= cnt_q + IdxW'(1);
      end
    end
    if (cmd_i.mac) begin
      prod_q <= coef_q[cnt_q] * hist_rd;
    end
    if (cmd_i.emit) begin
      if (y > YMax) begin
        out_data_q <= YMax[fbf_pkg::SampleW-1:0];
        out_sat_q  <= 1'b1;
      end else if (y < YMin) begin
        out_data_q <= YMin[fbf_pkg::SampleW-1:0];
        out_sat_q  <= 1'b1;
      end else begin
        out_data_q <= y[fbf_pkg::SampleW-1:0];
        out_sat_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_sat_o   = out_sat_q;

endmodule

FILE: rtl/core/fir_block_filter.sv
// top level of the block fir filter: stream ports and configuration write port
// depends on fbf_pkg, fbf_ctrl and fbf_datapath
// usage
//   input stream: each item either loads one q1.15 coefficient (action 0)
//   or filters one signed 24-bit sample (action 1). a sample flagged first of
//   block clears the sample history before it is used.
//   output stream: one item per filtered sample, the rounded sum of products
//   over the taps in use, saturated to 24 bits, with a clip flag in tuser.
//   configuration: one write sets taps_in_use (counts above 32 act as 32,
//   zero gives a zero output); cfg_ready_o is always high. write only while idle.
// sequence
//   after a coefficient load the block stays ready and takes the next item.
//   a sample is taken only when the previous one is done: one shared multiplier
//   handles one tap per cycle (none when taps_in_use is zero), the drain state
//   adds the last product and the finish state rounds into the output register.
// reset
//   coefficients clear to zero, history empties, taps_in_use returns to 32.
//   s_axis_tready rises the first cycle after reset is released.
// stalls
//   the output register holds a result while m_axis_tready is low; the block
//   still takes the next item and computes it, and then waits before writing
//   the new result until the register is free.
module fir_block_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [23:0] sample_in, [28:24] coef_index, [44:29] coef_value, [47:45] zero
  input  logic [fbf_pkg::InDataW-1:0]     s_axis_tdata,
  // [0] action, [1] first_of_block
  input  logic [fbf_pkg::InUserW-1:0]     s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [23:0] filtered_out
  output logic [fbf_pkg::OutDataW-1:0]    m_axis_tdata,
  // [0] saturated
  output logic [fbf_pkg::OutUserW-1:0]    m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fbf_pkg::TapsW-1:0]       cfg_data_i
);

  fbf_pkg::fbf_cmd_t  cmd;
  fbf_pkg::fbf_stat_t stat;
  logic signed [fbf_pkg::SampleW-1:0] out_data;
  logic                               out_sat;

  // configuration register is always writable
  assign cfg_ready_o = 1'b1;

  fbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser[0]),
    .stat_i      (stat),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd)
  );

  fbf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .sample_i     (s_axis_tdata[23:0]),
    .first_i      (s_axis_tuser[1]),
    .coef_index_i (s_axis_tdata[28:24]),
    .coef_value_i (s_axis_tdata[44:29]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (out_data),
    .out_sat_o    (out_sat)
  );

  assign m_axis_tdata = out_data;
  assign m_axis_tuser = out_sat;

endmodule
